@@ sv/acr_pkg.sv @@
// Shared types, field layouts and helper functions of the AABB collision resolver.
package acr_pkg;

    // Coordinate format: signed, 4 fraction bits, fixed by the stream field widths.
    localparam int COORD_BITS = 20;
    localparam int SIZE_BITS  = 19;
    localparam int MOVE_BITS  = 16;
    localparam int CNT_BITS   = 7;
    // Internal width for edge sums; covers coordinate plus two sizes without overflow.
    localparam int EXT_W      = COORD_BITS + 3;

    localparam logic signed [EXT_W-1:0] COORD_HI = EXT_W'(2**(COORD_BITS-1) - 1);
    localparam logic signed [EXT_W-1:0] COORD_LO = EXT_W'(-(2**(COORD_BITS-1)));

    // Configuration register indexes.
    localparam logic [1:0] REG_HITBOX_W  = 2'd0;
    localparam logic [1:0] REG_HITBOX_H  = 2'd1;
    localparam logic [1:0] REG_OBST_CNT  = 2'd2;

    // Input item payload, last field in the lowest bits.
    typedef struct packed {
        logic [3:0]                  pad;
        logic signed [MOVE_BITS-1:0]  move_y;
        logic signed [MOVE_BITS-1:0]  move_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_x;
        logic [SIZE_BITS-1:0]         rect_height;
        logic [SIZE_BITS-1:0]         rect_width;
        logic signed [COORD_BITS-1:0] rect_top;
        logic signed [COORD_BITS-1:0] rect_left;
        logic [5:0]                   entry_index;
    } acr_in_t;

    // Result item payload, last field in the lowest bits.
    typedef struct packed {
        logic [6:0]                   pad;
        logic                         on_ground;
        logic signed [MOVE_BITS-1:0]  new_move_y;
        logic signed [COORD_BITS-1:0] new_pos_y;
        logic signed [COORD_BITS-1:0] new_pos_x;
    } acr_out_t;

    // One obstacle table word.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] left;
        logic signed [COORD_BITS-1:0] top;
        logic [SIZE_BITS-1:0]         width;
        logic [SIZE_BITS-1:0]         height;
    } acr_entry_t;

    localparam int IN_TDATA_W  = $bits(acr_in_t);
    localparam int OUT_TDATA_W = $bits(acr_out_t);
    localparam int ENTRY_W     = $bits(acr_entry_t);

    // Controller states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_XSCAN = 4'b0010,
        ST_YSCAN = 4'b0100,
        ST_OUT   = 4'b1000
    } acr_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic step_load;
        logic entry_write;
        logic rd_en;
        logic x_apply;
        logic y_move;
        logic y_apply;
        logic out_load;
    } acr_cmd_t;

    // Clamp a widened coordinate to the signed coordinate range.
    function automatic logic [COORD_BITS-1:0] sat_coord(input logic signed [EXT_W-1:0] v);
        logic [COORD_BITS-1:0] r;
        if (v > COORD_HI) begin
            r = COORD_HI[COORD_BITS-1:0];
        end else if (v < COORD_LO) begin
            r = COORD_LO[COORD_BITS-1:0];
        end else begin
            r = v[COORD_BITS-1:0];
        end
        return r;
    endfunction

endpackage

@@ sv/acr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module acr_ram
    #(
        parameter int WIDTH = 8,
        parameter int DEPTH = 16,
        localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
    )
    (
        input  logic              aclk,
        input  logic              wr_en,
        input  logic [ADDR_W-1:0] wr_addr,
        input  logic [WIDTH-1:0]  wr_data,
        input  logic              rd_en,
        input  logic [ADDR_W-1:0] rd_addr,
        output logic [WIDTH-1:0]  rd_data
    );

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/acr_datapath.sv @@
// Datapath: obstacle table, hitbox registers, overlap test, push-back and result register.
module acr_datapath
    import acr_pkg::*;
    #(
        parameter int MAX_OBSTACLES = 64,
        localparam int AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1
    )
    (
        input  logic                   aclk,
        input  logic                   aresetn,
        input  acr_cmd_t               cmd,
        input  logic [AW-1:0]          rd_addr,
        input  logic                   cfg_we,
        input  logic [1:0]             cfg_index,
        input  logic [SIZE_BITS-1:0]   cfg_data,
        input  logic [IN_TDATA_W-1:0]  s_tdata,
        output logic [OUT_TDATA_W-1:0] m_tdata
    );

    acr_in_t    in_item;
    acr_entry_t wr_entry;
    acr_entry_t rd_entry;
    logic [ENTRY_W-1:0] rd_word;
    logic       entry_in_range;

    logic [SIZE_BITS-1:0] hit_w_reg;
    logic [SIZE_BITS-1:0] hit_h_reg;

    logic signed [COORD_BITS-1:0] x_reg, x_next;
    logic signed [COORD_BITS-1:0] y_reg, y_next;
    logic signed [MOVE_BITS-1:0]  mx_reg;
    logic signed [MOVE_BITS-1:0]  vy_reg, vy_next;
    logic                         ground_reg, ground_next;
    acr_out_t                     out_item_reg;

    // Widened operands; every one signed so compares stay signed.
    logic signed [EXT_W-1:0] x_e, y_e, mx_e, vy_e, px_e;
    logic signed [EXT_W-1:0] bw_e, bh_e, half_e, ceil_e;
    logic signed [EXT_W-1:0] l_e, t_e, w_e, h_e, r_e, b_e;
    logic signed [EXT_W-1:0] box_l, box_r, box_t;
    logic                    sizes_ok, overlap;
    logic                    mx_pos, mx_neg, vy_pos, vy_neg;

    assign in_item = s_tdata;

    // Hitbox size registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_w_reg <= '0;
            hit_h_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_index == REG_HITBOX_W) begin
                hit_w_reg <= cfg_data;
            end
            if (cfg_index == REG_HITBOX_H) begin
                hit_h_reg <= cfg_data;
            end
        end
    end

    // Obstacle table; loads to slots beyond the table are dropped.
    assign entry_in_range = (32'(in_item.entry_index) < 32'(MAX_OBSTACLES));
    assign wr_entry.left   = in_item.rect_left;
    assign wr_entry.top    = in_item.rect_top;
    assign wr_entry.width  = in_item.rect_width;
    assign wr_entry.height = in_item.rect_height;

    acr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_OBSTACLES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (cmd.entry_write && entry_in_range),
        .wr_addr (AW'(in_item.entry_index)),
        .wr_data (wr_entry),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    assign rd_entry = rd_word;

    // Operand extension.
    assign x_e    = EXT_W'(x_reg);
    assign y_e    = EXT_W'(y_reg);
    assign mx_e   = EXT_W'(in_item.move_x);
    assign vy_e   = EXT_W'(vy_reg);
    assign px_e   = EXT_W'(in_item.pos_x);
    assign bw_e   = EXT_W'(hit_w_reg);
    assign bh_e   = EXT_W'(hit_h_reg);
    assign half_e = EXT_W'(hit_w_reg[SIZE_BITS-1:1]);
    assign ceil_e = bw_e - half_e;
    assign l_e    = EXT_W'(rd_entry.left);
    assign t_e    = EXT_W'(rd_entry.top);
    assign w_e    = EXT_W'(rd_entry.width);
    assign h_e    = EXT_W'(rd_entry.height);
    assign r_e    = l_e + w_e;
    assign b_e    = t_e + h_e;

    // Strict overlap of the hitbox with the obstacle just read.
    assign box_l    = x_e - half_e;
    assign box_r    = x_e + ceil_e;
    assign box_t    = y_e - bh_e;
    assign sizes_ok = (hit_w_reg != '0) && (hit_h_reg != '0)
                   && (rd_entry.width != '0) && (rd_entry.height != '0);
    assign overlap  = sizes_ok && (box_l < r_e) && (l_e < box_r)
                   && (box_t < b_e) && (t_e < y_e);

    assign mx_pos = !mx_reg[MOVE_BITS-1] && (mx_reg != '0);
    assign mx_neg = mx_reg[MOVE_BITS-1];
    assign vy_pos = !vy_reg[MOVE_BITS-1] && (vy_reg != '0);
    assign vy_neg = vy_reg[MOVE_BITS-1];

    // Position and speed updates.
    always_comb begin
        x_next      = x_reg;
        y_next      = y_reg;
        vy_next     = vy_reg;
        ground_next = ground_reg;
        if (cmd.step_load) begin
            x_next      = sat_coord(px_e + mx_e);
            y_next      = in_item.pos_y;
            vy_next     = in_item.move_y;
            ground_next = 1'b0;
        end
        if (cmd.x_apply && overlap) begin
            if (mx_pos) begin
                x_next = sat_coord(l_e - ceil_e);
            end else if (mx_neg) begin
                x_next = sat_coord(r_e + half_e);
            end
        end
        if (cmd.y_move) begin
            y_next = sat_coord(y_e + vy_e);
        end
        if (cmd.y_apply && overlap) begin
            if (vy_pos) begin
                y_next      = sat_coord(t_e);
                vy_next     = '0;
                ground_next = 1'b1;
            end else if (vy_neg) begin
                y_next  = sat_coord(b_e + bh_e);
                vy_next = '0;
            end
        end
    end

    // Working registers; the horizontal move is kept for the push direction.
    always_ff @(posedge aclk) begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        vy_reg     <= vy_next;
        ground_reg <= ground_next;
        if (cmd.step_load) begin
            mx_reg <= in_item.move_x;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_item_reg.pad        <= '0;
            out_item_reg.on_ground  <= ground_reg;
            out_item_reg.new_move_y <= vy_reg;
            out_item_reg.new_pos_y  <= y_reg;
            out_item_reg.new_pos_x  <= x_reg;
        end
    end

    assign m_tdata = out_item_reg;

endmodule

@@ sv/acr_ctrl.sv @@
// Controller: item intake, two table scans per step, and the result handshake.
module acr_ctrl
    import acr_pkg::*;
    #(
        parameter int MAX_OBSTACLES = 64,
        localparam int AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1,
        localparam int CW = $clog2(MAX_OBSTACLES + 1),
        localparam int NW = (CW > CNT_BITS) ? CW : CNT_BITS
    )
    (
        input  logic                aclk,
        input  logic                aresetn,
        input  logic                s_tvalid,
        output logic                s_tready,
        input  logic                s_tuser,
        output logic                m_tvalid,
        input  logic                m_tready,
        input  logic                cfg_we,
        input  logic [1:0]          cfg_index,
        input  logic [CNT_BITS-1:0] cfg_count,
        output acr_cmd_t            cmd,
        output logic [AW-1:0]       rd_addr
    );

    acr_state_t          state_reg, state_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic                pend_reg, pend_next;
    logic                out_valid_reg, out_valid_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [NW-1:0]       count_ext;
    logic [CW-1:0]       scan_len;
    logic                accept;

    // Obstacle count register, clamped to the table depth for scanning.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cfg_we && (cfg_index == REG_OBST_CNT)) begin
            count_reg <= cfg_count;
        end
    end

    assign count_ext = NW'(count_reg);
    assign scan_len  = (count_ext > NW'(MAX_OBSTACLES)) ? CW'(MAX_OBSTACLES) : CW'(count_ext);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign rd_addr  = idx_reg[AW-1:0];
    assign m_tvalid = out_valid_reg;

    // Sequencer: a table read goes out in each scan cycle but the last, and its data is used in the next cycle.
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pend_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser) begin
                        cmd.step_load = 1'b1;
                        idx_next      = '0;
                        state_next    = ST_XSCAN;
                    end else begin
                        cmd.entry_write = 1'b1;
                    end
                end
            end
            ST_XSCAN: begin
                cmd.x_apply = pend_reg;
                if (idx_reg == scan_len) begin
                    cmd.y_move = 1'b1;
                    idx_next   = '0;
                    state_next = ST_YSCAN;
                end else begin
                    cmd.rd_en = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
            end
            ST_YSCAN: begin
                cmd.y_apply = pend_reg;
                if (idx_reg == scan_len) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.rd_en = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
            end
            ST_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid flag: set on load, cleared when the item is taken.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ sv/aabb_collision_resolver_core.sv @@
// Top level of the AABB collision resolver: controller, datapath and configuration port.
//
//  Channel   Direction  Handshake            Payload
//  s_        in         s_tvalid/s_tready    s_tdata (step or load fields), s_tuser (action)
//  m_        out        m_tvalid/m_tready    m_tdata (resolved position, speed, on_ground)
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A load item writes one table slot and leaves the input open for the next item.
// A step item closes the input from acceptance until its result is loaded; in between,
// the single read port of the obstacle table reads each of the N slots once in the x
// scan and once in the y scan, N being the clamped obstacle count.
// The result waits in an output register, and the next item is accepted while it waits;
// a step only stalls at its end if the previous result has still not been taken.
// Reset is synchronous and active low; the obstacle table holds no reset value.
module aabb_collision_resolver_core
    import acr_pkg::*;
    #(
        parameter int MAX_OBSTACLES = 64,
        localparam int AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1
    )
    (
        input  logic                   aclk,
        input  logic                   aresetn,
        input  logic                   s_tvalid,
        output logic                   s_tready,
        // Low to high: entry_index, rect_left, rect_top, rect_width, rect_height,
        // pos_x, pos_y, move_x, move_y, zero fill.
        input  logic [IN_TDATA_W-1:0]  s_tdata,
        // action: 0 load obstacle, 1 resolve step.
        input  logic                   s_tuser,
        output logic                   m_tvalid,
        input  logic                   m_tready,
        // Low to high: new_pos_x, new_pos_y, new_move_y, on_ground, zero fill.
        output logic [OUT_TDATA_W-1:0] m_tdata,
        input  logic                   cfg_valid,
        output logic                   cfg_ready,
        input  logic [1:0]             cfg_index,
        input  logic [SIZE_BITS-1:0]   cfg_data
    );

    acr_cmd_t      cmd;
    logic [AW-1:0] rd_addr;
    logic          cfg_we;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    acr_ctrl #(
        .MAX_OBSTACLES (MAX_OBSTACLES)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_count (cfg_data[CNT_BITS-1:0]),
        .cmd       (cmd),
        .rd_addr   (rd_addr)
    );

    acr_datapath #(
        .MAX_OBSTACLES (MAX_OBSTACLES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata)
    );

endmodule

@@ sv/acr_checker.sv @@
// Port-level checks of the collision resolver, bound to the top level.
module acr_checker
    import acr_pkg::*;
    (
        input logic                   aclk,
        input logic                   aresetn,
        input logic                   s_tvalid,
        input logic                   s_tready,
        input logic                   s_tuser,
        input logic                   m_tvalid,
        input logic                   m_tready,
        input logic [OUT_TDATA_W-1:0] m_tdata
    );

    // A result stays offered, unchanged, until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    // A load item never starts a scan, so intake stays open.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser |=> s_tready)
        else $error("load item blocked the input");

    // A step item closes the input once it is accepted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("input open during a step");

    // A new result never appears right after an item was accepted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result appeared directly after an accepted item");

    // Reset clears the result valid flag.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind aabb_collision_resolver_core acr_checker u_acr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ bench/aabb_step_checker.sv @@
// Channel monitor for the collision resolver: predicts each step result and compares it.
module aabb_step_checker
    import acr_pkg::*;
    #(
        parameter logic STEP_CODE = 1'b1,
        parameter int   SLOTS     = 64
    )
    (
        input  logic                   aclk,
        input  logic                   aresetn,
        input  logic                   s_tvalid,
        input  logic                   s_tready,
        input  logic [IN_TDATA_W-1:0]  s_tdata,
        input  logic                   s_tuser,
        input  logic                   m_tvalid,
        input  logic                   m_tready,
        input  logic [OUT_TDATA_W-1:0] m_tdata,
        input  logic                   cfg_valid,
        input  logic                   cfg_ready,
        input  logic [1:0]             cfg_index,
        input  logic [SIZE_BITS-1:0]   cfg_data,
        output int                     fail_count,
        output int                     waiting,
        output int                     checked,
        output int                     landings
    );
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CRD_MAX = longint'(2**(COORD_BITS-1)) - 1;
    localparam longint CRD_MIN = -CRD_MAX - 1;

    // Shadow copy of the configuration and the obstacle table.
    logic [SIZE_BITS-1:0]         box_w;
    logic [SIZE_BITS-1:0]         box_h;
    logic [CNT_BITS-1:0]          scan_cnt;
    logic signed [COORD_BITS-1:0] ob_left [SLOTS];
    logic signed [COORD_BITS-1:0] ob_top  [SLOTS];
    logic [SIZE_BITS-1:0]         ob_wid  [SLOTS];
    logic [SIZE_BITS-1:0]         ob_hgt  [SLOTS];

    // Results predicted for accepted step items, oldest first.
    acr_out_t resolved_q [$];

    function automatic longint clamp_coord(longint v);
        if (v > CRD_MAX) begin
            return CRD_MAX;
        end
        if (v < CRD_MIN) begin
            return CRD_MIN;
        end
        return v;
    endfunction

    // Strict overlap of the body hitbox (bottom-centre at x, y) with table slot k.
    function automatic bit box_hits(longint x, longint y, int k);
        longint bw, bh, bl, bt, l, t, r, b;
        bw = longint'(box_w);
        bh = longint'(box_h);
        bl = x - bw / 2;
        bt = y - bh;
        l  = longint'(ob_left[k]);
        t  = longint'(ob_top[k]);
        r  = l + longint'(ob_wid[k]);
        b  = t + longint'(ob_hgt[k]);
        return ((bl > l ? bl : l) < (bl + bw < r ? bl + bw : r)) &&
               ((bt > t ? bt : t) < (y < b ? y : b));
    endfunction

    // Move along x and push out, then along y and push out or land.
    function automatic acr_out_t resolve_step(acr_in_t it);
        longint   x, y, mx, vy, bw, bh, span;
        bit       landed;
        acr_out_t res;
        bw     = longint'(box_w);
        bh     = longint'(box_h);
        x      = longint'(it.pos_x);
        y      = longint'(it.pos_y);
        mx     = longint'(it.move_x);
        vy     = longint'(it.move_y);
        span   = (scan_cnt > SLOTS) ? SLOTS : scan_cnt;
        landed = 1'b0;

        x = clamp_coord(x + mx);
        for (int k = 0; k < span; k++) begin
            if (box_hits(x, y, k)) begin
                if (mx > 0) begin
                    x = clamp_coord(longint'(ob_left[k]) - bw + bw / 2);
                end else if (mx < 0) begin
                    x = clamp_coord(longint'(ob_left[k]) + longint'(ob_wid[k]) + bw / 2);
                end
            end
        end

        // Once the speed is zero, later contacts in this pass push nothing.
        y = clamp_coord(y + vy);
        for (int k = 0; k < span; k++) begin
            if (box_hits(x, y, k)) begin
                if (vy > 0) begin
                    y      = clamp_coord(longint'(ob_top[k]));
                    vy     = 0;
                    landed = 1'b1;
                end else if (vy < 0) begin
                    y  = clamp_coord(longint'(ob_top[k]) + longint'(ob_hgt[k]) + bh);
                    vy = 0;
                end
            end
        end

        res            = '0;
        res.new_pos_x  = x[COORD_BITS-1:0];
        res.new_pos_y  = y[COORD_BITS-1:0];
        res.new_move_y = vy[MOVE_BITS-1:0];
        res.on_ground  = landed;
        return res;
    endfunction

    // Register writes, item prediction and result comparison, in handshake order.
    always @(posedge aclk) begin
        acr_in_t  item;
        acr_out_t want;
        acr_out_t got;
        if (!aresetn) begin
            box_w    = '0;
            box_h    = '0;
            scan_cnt = '0;
            resolved_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_HITBOX_W: box_w = cfg_data;
                    REG_HITBOX_H: box_h = cfg_data;
                    REG_OBST_CNT: scan_cnt = cfg_data[CNT_BITS-1:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                item = acr_in_t'(s_tdata);
                if (s_tuser == STEP_CODE) begin
                    resolved_q.push_back(resolve_step(item));
                end else if (item.entry_index < SLOTS) begin
                    // A load to a slot beyond the table is dropped.
                    ob_left[item.entry_index] = item.rect_left;
                    ob_top[item.entry_index]  = item.rect_top;
                    ob_wid[item.entry_index]  = item.rect_width;
                    ob_hgt[item.entry_index]  = item.rect_height;
                end
            end

            if (m_tvalid && m_tready) begin
                got = acr_out_t'(m_tdata);
                checked++;
                if (resolved_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("Unexpected result item: x=%0d y=%0d vy=%0d ground=%0b",
                                 got.new_pos_x, got.new_pos_y, got.new_move_y, got.on_ground);
                    end
                end else begin
                    want = resolved_q.pop_front();
                    if (got.new_pos_x !== want.new_pos_x || got.new_pos_y !== want.new_pos_y ||
                        got.new_move_y !== want.new_move_y ||
                        got.on_ground !== want.on_ground) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("Mismatch on result %0d: expected x=%0d y=%0d vy=%0d g=%0b",
                                     checked, want.new_pos_x, want.new_pos_y,
                                     want.new_move_y, want.on_ground);
                            $display("    got x=%0d y=%0d vy=%0d g=%0b",
                                     got.new_pos_x, got.new_pos_y, got.new_move_y,
                                     got.on_ground);
                        end
                    end
                    if (want.on_ground) begin
                        landings++;
                    end
                end
            end
        end
        waiting = resolved_q.size();
    end

endmodule

@@ bench/tb_aabb_collision_resolver_core.sv @@
// Testbench top for the collision resolver: clock, reset, stimulus, receiver and verdict.
module tb_aabb_collision_resolver_core;
    timeunit 1ns;
    timeprecision 1ps;
    import acr_pkg::*;

    localparam logic ACT_LOAD      = 1'b0;
    localparam logic ACT_STEP      = 1'b1;
    localparam int   SLOTS         = 64;
    localparam int   SETTLE_CYCLES = 2 * SLOTS + 8;
    localparam int   LONG_HOLD     = 2000;
    localparam int   LIMIT_CYCLES  = 2_000_000;
    localparam int   MAX_SIZE      = 2**SIZE_BITS - 1;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [1:0]             cfg_index = '0;
    logic [SIZE_BITS-1:0]   cfg_data  = '0;

    int fail_count;
    int waiting;
    int checked;
    int landings;

    // Stimulus bookkeeping and a copy of the loaded layout used to aim steps.
    int     burst_left     = 0;
    int     stall_requests = 0;
    int     n_loads        = 0;
    int     n_steps        = 0;
    int     n_settings     = 0;
    int     n_scan         = 0;
    longint hb_w           = 0;
    longint hb_h           = 0;
    longint g_left [SLOTS];
    longint g_top  [SLOTS];
    longint g_wid  [SLOTS];
    longint g_hgt  [SLOTS];

    aabb_collision_resolver_core DUT (.*);

    aabb_step_checker #(.STEP_CODE(ACT_STEP), .SLOTS(SLOTS)) step_check (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint pick(longint lo, longint hi);
        return lo + longint'($urandom_range(32'(hi - lo), 0));
    endfunction

    // Step item; the obstacle fields carry junk that the block must ignore.
    function automatic acr_in_t make_step(longint x, longint y, longint mx, longint vy);
        acr_in_t d;
        d             = '0;
        d.entry_index = 6'($urandom);
        d.rect_left   = 20'($urandom);
        d.rect_top    = 20'($urandom);
        d.rect_width  = 19'($urandom);
        d.rect_height = 19'($urandom);
        d.pos_x       = 20'(x);
        d.pos_y       = 20'(y);
        d.move_x      = 16'(mx);
        d.move_y      = 16'(vy);
        return d;
    endfunction

    // Load item; the body fields carry junk.
    function automatic acr_in_t make_load(int k, longint l, longint t, longint w, longint h);
        acr_in_t d;
        d             = '0;
        d.entry_index = 6'(k);
        d.rect_left   = 20'(l);
        d.rect_top    = 20'(t);
        d.rect_width  = 19'(w);
        d.rect_height = 19'(h);
        d.pos_x       = 20'($urandom);
        d.pos_y       = 20'($urandom);
        d.move_x      = 16'($urandom);
        d.move_y      = 16'($urandom);
        return d;
    endfunction

    // Offer one item, in bursts with random gaps between them.
    task automatic send_item(input logic act, input acr_in_t d);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(24, 1);
            gap        = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(10, 1);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= act;
        do @(posedge aclk); while (!s_tready);
        if (act == ACT_STEP) begin
            n_steps++;
        end else begin
            n_loads++;
        end
    endtask

    // Stop offering, let every expected result arrive, then let a trailing load finish.
    task automatic settle();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (waiting != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write all three registers back to back.
    task automatic write_regs(input longint w, input longint h, input int n);
        logic [SIZE_BITS-1:0] vals [3];
        logic [1:0]           regs [3];
        vals[0] = SIZE_BITS'(w);
        vals[1] = SIZE_BITS'(h);
        vals[2] = SIZE_BITS'(n);
        regs[0] = REG_HITBOX_W;
        regs[1] = REG_HITBOX_H;
        regs[2] = REG_OBST_CNT;
        for (int k = 0; k < 3; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[k];
            cfg_data  <= vals[k];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        hb_w      = w;
        hb_h      = h;
        n_scan    = (n > SLOTS) ? SLOTS : n;
        n_settings++;
    endtask

    // Load one slot: mostly obstacles near the play area, some at the range limits,
    // some with zero size and some fully random.
    task automatic load_slot(input int k);
        longint l, t, w, h, span;
        span = 200 + ((hb_w + hb_h > 4000) ? 4000 : hb_w + hb_h);
        case ($urandom_range(19, 0))
            0: begin
                l = pick(-524288, 524287);
                t = pick(-524288, 524287);
                w = pick(0, MAX_SIZE);
                h = pick(0, MAX_SIZE);
            end
            1: begin
                l = $urandom_range(1, 0) ? pick(-524288, -521288) : pick(521287, 524287);
                t = $urandom_range(1, 0) ? pick(-524288, -521288) : pick(521287, 524287);
                w = pick(0, 6000);
                h = pick(0, 6000);
            end
            2: begin
                w = $urandom_range(1, 0) ? 0 : pick(0, 2000);
                h = (w == 0) ? pick(0, 2000) : 0;
                l = pick(-4000, 4000);
                t = pick(-4000, 4000);
            end
            default: begin
                l = pick(-6000, 6000);
                t = pick(-6000, 6000);
                w = pick(16, span);
                h = pick(16, span);
            end
        endcase
        g_left[k] = l;
        g_top[k]  = t;
        g_wid[k]  = w;
        g_hgt[k]  = h;
        send_item(ACT_LOAD, make_load(k, l, t, w, h));
    endtask

    // Step aimed at a scanned obstacle so that pushes and landings are common.
    task automatic aimed_step();
        longint x, y, mx, vy, reach_x, reach_y, mlim, vlim;
        int     k;
        reach_x = ((hb_w > 20000) ? 20000 : hb_w) + 32;
        reach_y = ((hb_h > 20000) ? 20000 : hb_h) + 32;
        if (n_scan == 0) begin
            x = pick(-6000, 6000);
            y = pick(-6000, 6000);
        end else begin
            k = $urandom_range(n_scan - 1, 0);
            x = g_left[k] + pick(-reach_x, g_wid[k] + reach_x);
            y = g_top[k] + pick(-reach_y / 2, g_hgt[k] + reach_y);
        end
        mlim = (hb_w + 256 > 32767) ? 32767 : hb_w + 256;
        vlim = (hb_h + 256 > 32767) ? 32767 : hb_h + 256;
        mx   = ($urandom_range(5, 0) == 0) ? 0 : pick(-mlim, mlim);
        case ($urandom_range(9, 0))
            0:       vy = 0;
            1, 2, 3: vy = pick(-vlim, -1);
            default: vy = pick(1, vlim);
        endcase
        if ($urandom_range(19, 0) == 0) begin
            mx = $urandom_range(1, 0) ? 32767 : -32768;
        end
        if ($urandom_range(19, 0) == 0) begin
            vy = $urandom_range(1, 0) ? 32767 : -32768;
        end
        send_item(ACT_STEP, make_step(x, y, mx, vy));
    endtask

    // One register setting: fill the scanned slots, then a random mix of items.
    task automatic run_phase(input longint w, input longint h, input int n, input int items,
                             input bit pressure);
        int roll;
        settle();
        write_regs(w, h, n);
        for (int k = 0; k < n_scan; k++) begin
            load_slot(k);
        end
        if (pressure) begin
            stall_requests++;
        end
        repeat (items) begin
            roll = $urandom_range(99, 0);
            if (roll < 8) begin
                load_slot($urandom_range(SLOTS - 1, 0));
            end else if (roll < 16) begin
                send_item(ACT_STEP, make_step(longint'($urandom), longint'($urandom),
                                              longint'($urandom), longint'($urandom)));
            end else begin
                aimed_step();
            end
        end
    endtask

    // Hand-placed scene: floor, wall, ceiling, a ledge on the floor and a zero-size box.
    // Hitbox is 160 wide and 320 high.
    task automatic directed();
        write_regs(160, 320, 5);
        send_item(ACT_LOAD, make_load(0, -4000, 1000, 8000, 160));
        send_item(ACT_LOAD, make_load(1, 400, 0, 160, 1000));
        send_item(ACT_LOAD, make_load(2, -4000, -800, 8000, 160));
        send_item(ACT_LOAD, make_load(3, -200, 990, 400, 100));
        send_item(ACT_LOAD, make_load(4, 0, 500, 0, 0));
        // Walk right into the wall, then left into it.
        send_item(ACT_STEP, make_step(0, 800, 500, 0));
        send_item(ACT_STEP, make_step(700, 800, -300, 0));
        // Overlap with no motion pushes nothing.
        send_item(ACT_STEP, make_step(480, 800, 0, 0));
        // Fall onto the floor; then onto floor and ledge, where only the first contact acts.
        send_item(ACT_STEP, make_step(-1000, 950, 0, 100));
        send_item(ACT_STEP, make_step(0, 950, 0, 100));
        // Jump into the ceiling.
        send_item(ACT_STEP, make_step(-1000, -250, 0, -200));
        // Touching edges are not overlaps.
        send_item(ACT_STEP, make_step(-1000, 1000, 0, 0));
        send_item(ACT_STEP, make_step(320, 800, 0, 50));
        // Zero-size obstacle inside the hitbox.
        send_item(ACT_STEP, make_step(0, 600, 0, 0));
        send_item(ACT_STEP, make_step(0, 600, 40, 30));
        // Free motion and saturation at both ends of the range.
        send_item(ACT_STEP, make_step(-2000, 0, 123, 45));
        send_item(ACT_STEP, make_step(524187, 524287, 32767, 32767));
        send_item(ACT_STEP, make_step(-524278, -524288, -32768, -32768));
        send_item(ACT_STEP, make_step(-524288, 524287, 32767, -32768));
        send_item(ACT_STEP, make_step(524287, -524288, -32768, 32767));
    endtask

    // Result receiver: changing ready patterns, plus a long hold-off on request.
    initial begin
        rx_pattern_t pattern;
        int          left;
        int          seen;
        int          hold;
        pattern = RX_OPEN;
        left    = 0;
        seen    = 0;
        hold    = 0;
        forever begin
            @(posedge aclk);
            if (stall_requests != seen) begin
                seen = stall_requests;
                hold = LONG_HOLD;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                if (left == 0) begin
                    pattern = rx_pattern_t'($urandom_range(3, 0));
                    left    = $urandom_range(400, 40);
                end
                left--;
                case (pattern)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom_range(1, 0));
                    RX_SPARSE: m_tready <= ($urandom_range(3, 0) == 0);
                    default:   m_tready <= ((left % 9) < 4);
                endcase
            end
        end
    end

    // Main sequence.
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        directed();
        run_phase(256, 512, 8, 150, 1'b1);
        run_phase(0, 480, 16, 150, 1'b0);
        run_phase(300, 0, 4, 120, 1'b0);
        run_phase(MAX_SIZE, MAX_SIZE, 3, 100, 1'b0);
        run_phase(96, 200, 64, 170, 1'b0);
        run_phase(333, 640, 100, 130, 1'b0);
        run_phase(129, 256, 127, 120, 1'b0);
        run_phase(1, 1, 0, 60, 1'b0);
        repeat (1) begin
            run_phase($urandom_range(2000, 0), $urandom_range(2000, 0),
                      $urandom_range(24, 1), 120, 1'b0);
        end
        settle();
        $display("Run covered %0d items (%0d loads, %0d steps) over %0d register settings.",
                 n_loads + n_steps, n_loads, n_steps, n_settings);
        $display("Results checked: %0d, landings: %0d, failures: %0d.",
                 checked, landings, fail_count);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #(LIMIT_CYCLES * 10);
        $display("Timeout: the run did not complete in time.");
        $display("*** FAILED ***");
        $finish;
    end

endmodule
